@@ src/rtpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpm_pkg
// types, codes and sizes shared by the route table cells and the top level
// ----------------------------------------------------------------------------
package rtpm_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PLEN_W      = 6;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISS      = 3'd1,
        ST_FULL      = 3'd2,
        ST_RANGE     = 3'd3,
        ST_PROTECTED = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0]       mask;
        logic [31:0]       net;
        logic [31:0]       hop;
        logic              direct;
        logic [PLEN_W-1:0] plen;
    } entry_t;

    typedef struct packed {
        logic        add_en;
        logic        rm_en;
        logic        direct_add;
        logic [31:0] addr;
        entry_t      new_entry;
    } cell_ctrl_t;

    typedef struct packed {
        logic hit;
        logic ins;
    } chain_t;

endpackage : rtpm_pkg
`default_nettype wire

@@ src/rtpm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpm_cell
// one table entry: match and insert-point search, shifts with its neighbors
// ----------------------------------------------------------------------------
module rtpm_cell
    import rtpm_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       valid,
    input  wire logic       pos_sel,
    input  wire logic       rm_sel,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    input  wire chain_t     chain_in,
    output chain_t          chain_out,
    output logic            hit_sel,
    output entry_t          entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match;
    logic   cand;

    assign match = valid && ((ctrl.addr & entry_reg.mask) == entry_reg.net);
    assign cand  = ctrl.direct_add ? pos_sel
                 : (!valid || (!entry_reg.direct && (entry_reg.plen < ctrl.new_entry.plen)));

    assign hit_sel       = match && !chain_in.hit;
    assign chain_out.hit = chain_in.hit || match;
    assign chain_out.ins = chain_in.ins || cand;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.add_en && chain_in.ins)
        begin
            entry_next = left_entry;
        end
        else if (ctrl.add_en && cand)
        begin
            entry_next = ctrl.new_entry;
        end
        else if (ctrl.rm_en && rm_sel)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule : rtpm_cell
`default_nettype wire

@@ src/route_table_prefix_match_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// route_table_prefix_match_top
// ordered routing table: add, remove by index, first-match lookup
// accepted op is registered, then executed; the cell row updates the table
// throughput: one operation per cycle unless the output stalls
// reset: entry count and handshake state cleared, entry contents left as is
// ----------------------------------------------------------------------------
module route_table_prefix_match_top
    import rtpm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] address,
    input  wire logic [31:0] net_mask,
    input  wire logic [31:0] hop_address,
    input  wire logic        is_direct,
    input  wire logic [3:0]  entry_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      next_hop,
    output logic             direct_hit,
    output logic [4:0]       entry_count
);

    logic              op_valid_reg;
    mode_t             mode_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       mask_reg;
    logic [31:0]       hop_reg;
    logic              direct_reg;
    logic [3:0]        idx_reg;
    logic [PLEN_W-1:0] plen_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              res_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [31:0]       next_hop_reg;
    logic [31:0]       next_hop_next;
    logic              direct_hit_reg;
    logic              direct_hit_next;
    logic [CNT_W-1:0]  entry_count_reg;

    logic              exec;
    logic              accept;
    logic              full;
    logic              range_bad;
    logic              prot;
    logic              add_ok;
    logic              rm_ok;
    logic              lookup_hit;
    logic [31:0]       hit_hop;
    logic              hit_direct;
    logic [PLEN_W-1:0] plen_in;

    cell_ctrl_t              ctrl;
    entry_t                  entries [TABLE_DEPTH];
    chain_t                  chain   [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0]  valid_vec;
    logic [TABLE_DEPTH-1:0]  pos_vec;
    logic [TABLE_DEPTH-1:0]  rm_vec;
    logic [TABLE_DEPTH-1:0]  idx_vec;
    logic [TABLE_DEPTH-1:0]  direct_vec;
    logic [TABLE_DEPTH-1:0]  sel_vec;

    assign exec     = op_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !op_valid_reg || exec;
    assign accept   = in_valid && in_ready;

    // prefix length of the incoming mask
    always_comb
    begin
        plen_in = '0;
        for (int b = 0; b < 32; b++)
        begin
            plen_in = plen_in + PLEN_W'(net_mask[b]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            valid_vec[i]  = 32'(i) < 32'(count_reg);
            pos_vec[i]    = (count_reg == '0) ? (i == 0) : (i == 1);
            rm_vec[i]     = 32'(i) >= 32'(idx_reg);
            idx_vec[i]    = 32'(i) == 32'(idx_reg);
            direct_vec[i] = entries[i].direct;
        end
    end

    assign full      = 32'(count_reg) >= 32'(TABLE_DEPTH);
    assign range_bad = 32'(idx_reg) >= 32'(count_reg);
    assign prot      = |(direct_vec & idx_vec);
    assign add_ok    = (mode_reg == MODE_ADD) && !full;
    assign rm_ok     = (mode_reg == MODE_REMOVE) && !range_bad && !prot;

    assign ctrl.add_en           = exec && add_ok;
    assign ctrl.rm_en            = exec && rm_ok;
    assign ctrl.direct_add       = direct_reg;
    assign ctrl.addr             = addr_reg;
    assign ctrl.new_entry.mask   = mask_reg;
    assign ctrl.new_entry.net    = addr_reg;
    assign ctrl.new_entry.hop    = direct_reg ? 32'd0 : hop_reg;
    assign ctrl.new_entry.direct = direct_reg;
    assign ctrl.new_entry.plen   = plen_reg;

    assign chain[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        if (g == 0)
        begin : g_first
            assign left_e = ctrl.new_entry;
        end
        else
        begin : g_mid
            assign left_e = entries[g-1];
        end
        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign right_e = entries[g];
        end
        else
        begin : g_inner
            assign right_e = entries[g+1];
        end
        rtpm_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (valid_vec[g]),
            .pos_sel     (pos_vec[g]),
            .rm_sel      (rm_vec[g]),
            .left_entry  (left_e),
            .right_entry (right_e),
            .chain_in    (chain[g]),
            .chain_out   (chain[g+1]),
            .hit_sel     (sel_vec[g]),
            .entry       (entries[g])
        );
    end

    assign lookup_hit = chain[TABLE_DEPTH].hit;

    always_comb
    begin
        hit_hop    = '0;
        hit_direct = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_hop    = hit_hop | (sel_vec[i] ? entries[i].hop : 32'd0);
            hit_direct = hit_direct | (sel_vec[i] && entries[i].direct);
        end
    end

    always_comb
    begin
        status_next     = ST_OK;
        next_hop_next   = '0;
        direct_hit_next = 1'b0;
        count_next      = count_reg;
        case (mode_reg)
            MODE_LOOKUP:
            begin
                if (lookup_hit)
                begin
                    next_hop_next   = hit_direct ? 32'd0 : hit_hop;
                    direct_hit_next = hit_direct;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            MODE_ADD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (range_bad)
                begin
                    status_next = ST_RANGE;
                end
                else if (prot)
                begin
                    status_next = ST_PROTECTED;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                op_valid_reg <= 1'b1;
            end
            else if (exec)
            begin
                op_valid_reg <= 1'b0;
            end
            if (exec)
            begin
                res_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // operation and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode_t'(mode);
            addr_reg   <= address;
            mask_reg   <= net_mask;
            hop_reg    <= hop_address;
            direct_reg <= is_direct;
            idx_reg    <= entry_index;
            plen_reg   <= plen_in;
        end
        if (exec)
        begin
            status_reg      <= status_next;
            next_hop_reg    <= next_hop_next;
            direct_hit_reg  <= direct_hit_next;
            entry_count_reg <= count_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign status      = status_reg;
    assign next_hop    = next_hop_reg;
    assign direct_hit  = direct_hit_reg;
    assign entry_count = 5'(entry_count_reg);

endmodule : route_table_prefix_match_top
`default_nettype wire
